>>> rtl/sope_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sope_pkg
// Shared types and constants of the set operation engine.
// ----------------------------------------------------------------------------
package sope_pkg;

    localparam int DEF_SET_DEPTH  = 32;
    localparam int VALUE_W        = 32;
    localparam int OP_W           = 2;
    localparam int COUNT_W        = 7;
    localparam int CMD_FIFO_DEPTH = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INTERSECT  = 2'd0,
        OP_UNION      = 2'd1,
        OP_DIFFERENCE = 2'd2
    } set_op_t;

    // One classified input beat handed from the front to the back.
    typedef struct packed {
        logic               store;
        logic               sel;
        logic               close;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               present;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } res_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_F_RD,
        ST_F_WAIT,
        ST_S_RD,
        ST_S_CMP,
        ST_U_RD,
        ST_U_WAIT,
        ST_D_RD,
        ST_D_CMP,
        ST_E_RD,
        ST_E_OUT
    } back_state_t;

endpackage

>>> rtl/sope_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sope_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sope_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sope_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sope_front
// Input side: tracks which set is loading, drops stray beats and queues
// store and close commands for the back end.
// ----------------------------------------------------------------------------
module sope_front
    import sope_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               set_select,
    input  logic [VALUE_W-1:0] element_value,
    input  logic               element_present,
    input  logic               end_of_set,
    output logic               cmd_push,
    output cmd_t               cmd,
    input  logic               cmd_full
);

    logic loading_second_reg;
    logic loading_second_next;
    logic accept;
    logic match;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign match  = (set_select == loading_second_reg);

    always_comb
    begin
        loading_second_next = loading_second_reg;
        if (accept && match && end_of_set)
        begin
            loading_second_next = ~set_select;
        end
    end

    assign cmd_push  = accept && match && (element_present || (end_of_set && set_select));
    assign cmd.store = element_present;
    assign cmd.sel   = set_select;
    assign cmd.close = end_of_set && set_select;
    assign cmd.value = element_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loading_second_reg <= 1'b0;
        end
        else
        begin
            loading_second_reg <= loading_second_next;
        end
    end

endmodule

>>> rtl/sope_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sope_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module sope_cmd_fifo
    import sope_pkg::*;
#(
    parameter int DEPTH = CMD_FIFO_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/sope_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sope_back
// Execution side: writes set elements into the stores, then walks the
// stores to build the deduplicated result and streams it out.
// ----------------------------------------------------------------------------
module sope_back
    import sope_pkg::*;
#(
    parameter int SET_DEPTH = DEF_SET_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [OP_W-1:0] set_operation,
    input  logic            cmd_empty,
    input  cmd_t            cmd,
    output logic            cmd_pop,
    output logic            out_valid,
    output res_t            out_item,
    input  logic            out_pop
);

    localparam int SET_AW    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int RES_DEPTH = 2 * SET_DEPTH;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int RC_W      = $clog2(RES_DEPTH + 1);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [CNT_W-1:0]   fcnt_reg;
    logic [CNT_W-1:0]   fcnt_next;
    logic [CNT_W-1:0]   scnt_reg;
    logic [CNT_W-1:0]   scnt_next;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   i_next;
    logic [CNT_W-1:0]   j_reg;
    logic [CNT_W-1:0]   j_next;
    logic [RC_W-1:0]    r_reg;
    logic [RC_W-1:0]    r_next;
    logic [RC_W-1:0]    e_reg;
    logic [RC_W-1:0]    e_next;
    logic [RC_W-1:0]    k_reg;
    logic [RC_W-1:0]    k_next;
    logic [VALUE_W-1:0] cand_reg;
    logic [VALUE_W-1:0] cand_next;
    logic               phase2_reg;
    logic               phase2_next;
    logic               dropped_reg;
    logic               dropped_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               out_item_reg;
    res_t               out_item_next;

    logic               is_union;
    logic               is_diff;
    logic               out_free;
    logic               e_last;

    logic               first_we;
    logic               first_re;
    logic [VALUE_W-1:0] first_rdata;
    logic               second_we;
    logic               second_re;
    logic [VALUE_W-1:0] second_rdata;
    logic               result_we;
    logic               result_re;
    logic [RES_AW-1:0]  result_raddr;
    logic [VALUE_W-1:0] result_rdata;

    assign is_union = (set_operation == OP_UNION);
    assign is_diff  = (set_operation == OP_DIFFERENCE);
    assign out_free = !out_valid_reg || out_pop;
    assign e_last   = ((e_reg + 1'b1) == k_reg);
    assign result_raddr = (state_reg == ST_E_RD) ? e_reg[RES_AW-1:0] : r_reg[RES_AW-1:0];

    sope_ram #(.WIDTH(VALUE_W), .DEPTH(SET_DEPTH)) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (fcnt_reg[SET_AW-1:0]),
        .wdata (cmd.value),
        .re    (first_re),
        .raddr (i_reg[SET_AW-1:0]),
        .rdata (first_rdata)
    );

    sope_ram #(.WIDTH(VALUE_W), .DEPTH(SET_DEPTH)) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (scnt_reg[SET_AW-1:0]),
        .wdata (cmd.value),
        .re    (second_re),
        .raddr (j_reg[SET_AW-1:0]),
        .rdata (second_rdata)
    );

    sope_ram #(.WIDTH(VALUE_W), .DEPTH(RES_DEPTH)) u_result_ram (
        .clk   (clk),
        .we    (result_we),
        .waddr (k_reg[RES_AW-1:0]),
        .wdata (cand_reg),
        .re    (result_re),
        .raddr (result_raddr),
        .rdata (result_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        fcnt_next      = fcnt_reg;
        scnt_next      = scnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        r_next         = r_reg;
        e_next         = e_reg;
        k_next         = k_reg;
        cand_next      = cand_reg;
        phase2_next    = phase2_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !out_pop;
        out_item_next  = out_item_reg;
        cmd_pop        = 1'b0;
        first_we       = 1'b0;
        first_re       = 1'b0;
        second_we      = 1'b0;
        second_re      = 1'b0;
        result_we      = 1'b0;
        result_re      = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.store)
                    begin
                        if (!cmd.sel)
                        begin
                            if (fcnt_reg < CNT_W'(SET_DEPTH))
                            begin
                                first_we  = 1'b1;
                                fcnt_next = fcnt_reg + 1'b1;
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (scnt_reg < CNT_W'(SET_DEPTH))
                            begin
                                second_we = 1'b1;
                                scnt_next = scnt_reg + 1'b1;
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                    end
                    if (cmd.close)
                    begin
                        i_next      = '0;
                        k_next      = '0;
                        phase2_next = 1'b0;
                        state_next  = ST_F_RD;
                    end
                end
            end
            ST_F_RD:
            begin
                if (i_reg == fcnt_reg)
                begin
                    if (is_union)
                    begin
                        phase2_next = 1'b1;
                        j_next      = '0;
                        state_next  = ST_U_RD;
                    end
                    else
                    begin
                        e_next     = '0;
                        state_next = ST_E_RD;
                    end
                end
                else
                begin
                    first_re   = 1'b1;
                    state_next = ST_F_WAIT;
                end
            end
            ST_F_WAIT:
            begin
                cand_next = first_rdata;
                j_next    = '0;
                r_next    = '0;
                state_next = is_union ? ST_D_RD : ST_S_RD;
            end
            ST_S_RD:
            begin
                if (j_reg == scnt_reg)
                begin
                    if (is_diff)
                    begin
                        r_next     = '0;
                        state_next = ST_D_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_F_RD;
                    end
                end
                else
                begin
                    second_re  = 1'b1;
                    state_next = ST_S_CMP;
                end
            end
            ST_S_CMP:
            begin
                if (second_rdata == cand_reg)
                begin
                    if (is_diff)
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_F_RD;
                    end
                    else
                    begin
                        r_next     = '0;
                        state_next = ST_D_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_U_RD:
            begin
                if (j_reg == scnt_reg)
                begin
                    e_next     = '0;
                    state_next = ST_E_RD;
                end
                else
                begin
                    second_re  = 1'b1;
                    state_next = ST_U_WAIT;
                end
            end
            ST_U_WAIT:
            begin
                cand_next  = second_rdata;
                r_next     = '0;
                state_next = ST_D_RD;
            end
            ST_D_RD:
            begin
                if (r_reg == k_reg)
                begin
                    result_we = 1'b1;
                    k_next    = k_reg + 1'b1;
                    if (phase2_reg)
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_U_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_F_RD;
                    end
                end
                else
                begin
                    result_re  = 1'b1;
                    state_next = ST_D_CMP;
                end
            end
            ST_D_CMP:
            begin
                if (result_rdata == cand_reg)
                begin
                    if (phase2_reg)
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_U_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_F_RD;
                    end
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_D_RD;
                end
            end
            ST_E_RD:
            begin
                if (k_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next         = 1'b1;
                        out_item_next.value    = '0;
                        out_item_next.present  = 1'b0;
                        out_item_next.last     = 1'b1;
                        out_item_next.count    = '0;
                        out_item_next.overflow = dropped_reg;
                        fcnt_next              = '0;
                        scnt_next              = '0;
                        dropped_next           = 1'b0;
                        state_next             = ST_LOAD;
                    end
                end
                else
                begin
                    result_re  = 1'b1;
                    state_next = ST_E_OUT;
                end
            end
            ST_E_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.value    = result_rdata;
                    out_item_next.present  = 1'b1;
                    out_item_next.last     = e_last;
                    out_item_next.count    = COUNT_W'(k_reg);
                    out_item_next.overflow = dropped_reg;
                    if (e_last)
                    begin
                        fcnt_next    = '0;
                        scnt_next    = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = ST_E_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        r_reg        <= r_next;
        e_reg        <= e_next;
        k_reg        <= k_next;
        cand_reg     <= cand_next;
        phase2_reg   <= phase2_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fcnt_reg      <= '0;
            scnt_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            scnt_reg      <= scnt_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> rtl/set_operation_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_operation_engine_core
// Set intersection, union and difference over two loaded sets of signed
// 32-bit integers, results deduplicated in order of first appearance.
// ----------------------------------------------------------------------------
// Loading beats: one per cycle, sustained while the back end is loading,
// through a 4-entry command queue that fills while it walks the stores.
// Closing beat: each first-set element is compared with the second set (not
// for union) and the result so far, then for union each second-set element
// with it, on the registered-read stores; results then leave one at a time.
// Reset clears control state and the set size counters; the walk indices, output item and stores are not cleared.
// ----------------------------------------------------------------------------
module set_operation_engine_core
    import sope_pkg::*;
#(
    parameter int SET_DEPTH = DEF_SET_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      set_select,
    input  logic signed [VALUE_W-1:0] element_value,
    input  logic                      element_present,
    input  logic                      end_of_set,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] result_value,
    output logic                      result_present,
    output logic                      result_last,
    output logic [COUNT_W-1:0]        result_count,
    output logic                      overflow_seen,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [OP_W-1:0]           cfg_data
);

    logic [OP_W-1:0] set_operation_reg;
    logic            cmd_push;
    logic            cmd_full;
    logic            cmd_pop;
    logic            cmd_empty;
    cmd_t            cmd_in;
    cmd_t            cmd_out;
    logic            out_valid;
    res_t            out_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_operation_reg <= OP_INTERSECT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            set_operation_reg <= cfg_data;
        end
    end

    sope_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .set_select      (set_select),
        .element_value   (element_value),
        .element_present (element_present),
        .end_of_set      (end_of_set),
        .cmd_push        (cmd_push),
        .cmd             (cmd_in),
        .cmd_full        (cmd_full)
    );

    sope_cmd_fifo #(.DEPTH(CMD_FIFO_DEPTH)) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    sope_back #(.SET_DEPTH(SET_DEPTH)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .set_operation (set_operation_reg),
        .cmd_empty     (cmd_empty),
        .cmd           (cmd_out),
        .cmd_pop       (cmd_pop),
        .out_valid     (out_valid),
        .out_item      (out_item),
        .out_pop       (pop)
    );

    assign empty          = !out_valid;
    assign result_value   = $signed(out_item.value);
    assign result_present = out_item.present;
    assign result_last    = out_item.last;
    assign result_count   = out_item.count;
    assign overflow_seen  = out_item.overflow;

`ifndef SYNTHESIS
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result_present |-> result_last && result_count == '0)
        else $error("empty-result beat malformed");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result_present |-> result_count != '0)
        else $error("element beat with zero count");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queued while queue full");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");
`endif

endmodule
